[rtl/pbms_pkg.sv]
// ----------------------------------------------------------------------------
// pbms_pkg
// Types, codes and constants shared by the pellet burner mode sequencer.
// ----------------------------------------------------------------------------
package pbms_pkg;

    localparam int MODE_TIMER_BITS     = 24;
    localparam int MAX_PENDING_PRESSES = 15;
    localparam int PRESS_BITS          = 4;
    localparam int PHASE_TIMER_BITS    = 16;
    localparam int CFG_INDEX_BITS      = 8;
    localparam int CFG_DATA_BITS       = 60;
    localparam int TABLE_BITS          = 60;
    localparam int SPAN_BITS           = 24;
    localparam int PROG_LEN_BITS       = 12;
    localparam int START_LEN_BITS      = 15;
    localparam int NUM_PHASE_SLOTS     = 6;
    localparam int CMP_BITS            = 33;

    localparam logic [PHASE_TIMER_BITS-1:0] CLEAN_FILL_TICKS  = 16'd1100;
    localparam logic [PHASE_TIMER_BITS-1:0] CLEAN_STALL_TICKS = 16'd2900;

    localparam logic [2:0] CLEAN_SLOT = 3'd5;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_START = 4'd1,
        MODE_P1    = 4'd2,
        MODE_P2    = 4'd3,
        MODE_P3    = 4'd4,
        MODE_P4    = 4'd5,
        MODE_P5    = 4'd6,
        MODE_OFF   = 4'd7,
        MODE_CLEAN = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        PH_FILL   = 2'd0,
        PH_STALL  = 2'd1,
        PH_IFILL  = 2'd2,
        PH_ISTALL = 2'd3
    } phase_t;

    localparam logic [2:0] FAN_IDLE  = 3'd0;
    localparam logic [2:0] FAN_START = 3'd3;
    localparam logic [2:0] FAN_HIGH  = 3'd6;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FILL_TABLE     = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STALL_TABLE    = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STARTUP_PHASES = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STARTUP_TICKS  = 8'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLEAN_INTERVAL = 8'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLEAN_TICKS    = 8'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_DWELL      = 8'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TURN_OFF_TICKS = 8'd7;

    typedef struct packed {
        logic [TABLE_BITS-1:0] fill_table;
        logic [TABLE_BITS-1:0] stall_table;
        logic [TABLE_BITS-1:0] startup_phases;
        logic [SPAN_BITS-1:0]  startup_ticks;
        logic [SPAN_BITS-1:0]  clean_interval;
        logic [SPAN_BITS-1:0]  clean_ticks;
        logic [SPAN_BITS-1:0]  min_dwell;
        logic [SPAN_BITS-1:0]  turn_off_ticks;
    } cfg_t;

    typedef struct packed {
        mode_t                        mode;
        phase_t                       start_phase;
        logic [NUM_PHASE_SLOTS-1:0]   prog_stall;
        logic [PHASE_TIMER_BITS-1:0]  phase_timer;
        logic [MODE_TIMER_BITS-1:0]   mode_timer;
        logic                         long_latched;
        logic [PRESS_BITS-1:0]        press_count;
        logic                         feeder;
        logic                         heater;
        logic [2:0]                   fan;
    } state_t;

    typedef struct packed {
        logic [3:0]            mode;
        logic [1:0]            feed_phase;
        logic [2:0]            fan_code;
        logic                  feeder_on;
        logic                  heater_on;
        logic [PRESS_BITS-1:0] pending_presses;
    } res_t;

endpackage

[rtl/pbms_if.sv]
// ----------------------------------------------------------------------------
// pbms interfaces
// Tick, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface pbms_in_if;
    logic valid;
    logic ready;
    logic long_press;
    logic short_press;

    modport source (output valid, output long_press, output short_press, input ready);
    modport sink   (input valid, input long_press, input short_press, output ready);
endinterface

interface pbms_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] mode;
    logic [1:0] feed_phase;
    logic [2:0] fan_code;
    logic       feeder_on;
    logic       heater_on;
    logic [3:0] pending_presses;

    modport source (output valid, output mode, output feed_phase, output fan_code,
                    output feeder_on, output heater_on, output pending_presses,
                    input ready);
    modport sink   (input valid, input mode, input feed_phase, input fan_code,
                    input feeder_on, input heater_on, input pending_presses,
                    output ready);
endinterface

interface pbms_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [59:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/pbms_step.sv]
// ----------------------------------------------------------------------------
// pbms_step
// Next-state and result logic for one tick of the mode sequencer.
// ----------------------------------------------------------------------------
module pbms_step
    import pbms_pkg::*;
(
    input  state_t st,
    input  cfg_t   cfg,
    input  logic   long_press,
    input  logic   short_press,
    output state_t st_next,
    output res_t   res
);

    state_t                      nx;
    mode_t                       nm;
    logic [MODE_TIMER_BITS-1:0]  mt_bump;
    logic [2:0]                  pidx;
    logic [PHASE_TIMER_BITS-1:0] fill_len;
    logic [PHASE_TIMER_BITS-1:0] stall_len;
    logic [1:0]                  out_phase;

    always_comb
    begin
        nx = st;
        nm = st.mode;
        nx.long_latched = st.long_latched | long_press;
        if (short_press && (st.press_count < PRESS_BITS'(MAX_PENDING_PRESSES)))
            nx.press_count = st.press_count + 1'b1;
        if (st.phase_timer != '1)
            nx.phase_timer = st.phase_timer + 1'b1;
        mt_bump = (st.mode_timer != '1) ? st.mode_timer + 1'b1 : st.mode_timer;

        case (st.mode)
            MODE_P1: pidx = 3'd0;
            MODE_P2: pidx = 3'd1;
            MODE_P3: pidx = 3'd2;
            MODE_P4: pidx = 3'd3;
            MODE_P5: pidx = 3'd4;
            default: pidx = CLEAN_SLOT;
        endcase

        if (pidx == CLEAN_SLOT)
        begin
            fill_len  = CLEAN_FILL_TICKS;
            stall_len = CLEAN_STALL_TICKS;
        end
        else
        begin
            fill_len  = PHASE_TIMER_BITS'(cfg.fill_table[PROG_LEN_BITS*pidx +: PROG_LEN_BITS]);
            stall_len = PHASE_TIMER_BITS'(cfg.stall_table[PROG_LEN_BITS*pidx +: PROG_LEN_BITS]);
        end

        case (st.mode)
            MODE_IDLE:
            begin
                if (nx.long_latched)
                    nm = MODE_START;
            end
            MODE_START:
            begin
                nx.mode_timer = mt_bump;
                case (st.start_phase)
                    PH_IFILL:
                    begin
                        nx.feeder = 1'b1;
                        nx.heater = 1'b1;
                        nx.fan    = FAN_START;
                        if (nx.phase_timer >
                            PHASE_TIMER_BITS'(cfg.startup_phases[0 +: START_LEN_BITS]))
                        begin
                            nx.feeder      = 1'b0;
                            nx.phase_timer = '0;
                            nx.start_phase = PH_ISTALL;
                        end
                    end
                    PH_ISTALL:
                    begin
                        if (nx.phase_timer > PHASE_TIMER_BITS'(
                                cfg.startup_phases[START_LEN_BITS +: START_LEN_BITS]))
                        begin
                            nx.phase_timer = '0;
                            nx.start_phase = PH_FILL;
                        end
                    end
                    PH_FILL:
                    begin
                        nx.feeder = 1'b1;
                        if (nx.phase_timer > PHASE_TIMER_BITS'(
                                cfg.startup_phases[2*START_LEN_BITS +: START_LEN_BITS]))
                        begin
                            nx.feeder      = 1'b0;
                            nx.phase_timer = '0;
                            nx.start_phase = PH_STALL;
                        end
                    end
                    default:
                    begin
                        if (nx.phase_timer > PHASE_TIMER_BITS'(
                                cfg.startup_phases[3*START_LEN_BITS +: START_LEN_BITS]))
                        begin
                            nx.phase_timer = '0;
                            nx.start_phase = PH_FILL;
                        end
                    end
                endcase
                if (CMP_BITS'(nx.mode_timer) >= CMP_BITS'(cfg.startup_ticks))
                    nm = MODE_P1;
                if (nx.long_latched)
                    nm = MODE_OFF;
            end
            MODE_P1, MODE_P2, MODE_P3, MODE_P4, MODE_P5, MODE_CLEAN:
            begin
                nx.mode_timer = mt_bump;
                if (!st.prog_stall[pidx])
                begin
                    nx.feeder = 1'b1;
                    if (nx.phase_timer > fill_len)
                    begin
                        nx.feeder          = 1'b0;
                        nx.phase_timer     = '0;
                        nx.prog_stall[pidx] = 1'b1;
                    end
                end
                else if (nx.phase_timer > stall_len)
                begin
                    nx.phase_timer      = '0;
                    nx.prog_stall[pidx] = 1'b0;
                end

                if (st.mode == MODE_CLEAN)
                begin
                    if ((CMP_BITS'(nx.mode_timer) >= CMP_BITS'(cfg.clean_ticks)) &&
                        nx.prog_stall[CLEAN_SLOT])
                        nm = MODE_P1;
                end
                else
                begin
                    if (CMP_BITS'(nx.mode_timer) >= CMP_BITS'(cfg.clean_interval))
                        nm = MODE_CLEAN;
                    if ((nx.press_count != '0) &&
                        (CMP_BITS'(nx.mode_timer) > CMP_BITS'(cfg.min_dwell)))
                    begin
                        nm = (st.mode == MODE_P5) ? MODE_P1 : mode_t'(st.mode + 4'd1);
                        nx.press_count = nx.press_count - 1'b1;
                    end
                end
                if (nx.long_latched)
                    nm = MODE_OFF;
            end
            MODE_OFF:
            begin
                nx.mode_timer = mt_bump;
                if (CMP_BITS'(nx.mode_timer) >= CMP_BITS'(cfg.turn_off_ticks))
                    nm = MODE_IDLE;
            end
            default:
            begin
                nm = st.mode;
            end
        endcase

        if (nm != st.mode)
        begin
            nx.mode_timer = '0;
            if (st.mode == MODE_START)
            begin
                nx.heater = 1'b0;
                if (nx.press_count != '0)
                    nx.press_count = nx.press_count - 1'b1;
            end
            else if (st.mode == MODE_OFF)
            begin
                nx.heater = 1'b0;
                nx.feeder = 1'b0;
            end

            if (nm == MODE_IDLE)
            begin
                nx.fan = FAN_IDLE;
            end
            else
            begin
                nx.long_latched = 1'b0;
                nx.phase_timer  = '0;
                if (nm == MODE_START)
                    nx.start_phase = PH_IFILL;
                else if (nm inside {[MODE_P1:MODE_P5]})
                    nx.fan = 3'(nm - 4'd1);
                else if (nm == MODE_OFF)
                begin
                    nx.press_count = '0;
                    nx.fan         = FAN_HIGH;
                    nx.feeder      = 1'b0;
                end
                else
                    nx.fan = FAN_HIGH;
            end
        end
        nx.mode = nm;

        case (nm)
            MODE_START: out_phase = nx.start_phase;
            MODE_P1:    out_phase = {1'b0, nx.prog_stall[0]};
            MODE_P2:    out_phase = {1'b0, nx.prog_stall[1]};
            MODE_P3:    out_phase = {1'b0, nx.prog_stall[2]};
            MODE_P4:    out_phase = {1'b0, nx.prog_stall[3]};
            MODE_P5:    out_phase = {1'b0, nx.prog_stall[4]};
            MODE_CLEAN: out_phase = {1'b0, nx.prog_stall[CLEAN_SLOT]};
            default:    out_phase = PH_FILL;
        endcase

        st_next             = nx;
        res.mode            = nx.mode;
        res.feed_phase      = out_phase;
        res.fan_code        = nx.fan;
        res.feeder_on       = nx.feeder;
        res.heater_on       = nx.heater;
        res.pending_presses = nx.press_count;
    end

endmodule

[rtl/pellet_burner_mode_sequencer.sv]
// ----------------------------------------------------------------------------
// pellet_burner_mode_sequencer
// Burner mode, feed phase, fan, feeder and heater control, one tick per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one request per 100 ms tick, carrying long_press and short_press.
//   out_ch : one result per request: mode, feed_phase, fan_code, feeder_on,
//            heater_on and pending_presses as they stand after that tick.
//   cfg    : register writes (index 0..7, data in the low bits); always ready.
//            Write only while no request is in flight.
// Latency: the result of a request is valid in the cycle after it is taken.
// Throughput: one request per cycle while out_ch is not stalled; the tick logic is a single pass between
//   the state registers and the result register.
// Reset: idle mode, all timers and counters cleared, feeder, heater and fan
//   off, configuration at its reset values, no result pending.
// Stall: a held result keeps its value; in_ch stays ready while the result is
//   taken in the same cycle, and drops otherwise until the receiver takes it.
// ----------------------------------------------------------------------------
module pellet_burner_mode_sequencer
    import pbms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pbms_in_if.sink    in_ch,
    pbms_out_if.source out_ch,
    pbms_cfg_if.sink   cfg
);

    state_t state_reg;
    state_t state_next;
    res_t   res_reg;
    res_t   res_next;
    cfg_t   cfg_reg;
    logic   out_valid_reg;
    logic   in_acc;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign cfg.ready   = 1'b1;

    pbms_step u_step (
        .st          (state_reg),
        .cfg         (cfg_reg),
        .long_press  (in_ch.long_press),
        .short_press (in_ch.short_press),
        .st_next     (state_next),
        .res         (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fill_table     <= '0;
            cfg_reg.stall_table    <= '0;
            cfg_reg.startup_phases <= '0;
            cfg_reg.startup_ticks  <= SPAN_BITS'(6000);
            cfg_reg.clean_interval <= SPAN_BITS'(36000);
            cfg_reg.clean_ticks    <= SPAN_BITS'(200);
            cfg_reg.min_dwell      <= SPAN_BITS'(50);
            cfg_reg.turn_off_ticks <= SPAN_BITS'(3000);
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_FILL_TABLE:     cfg_reg.fill_table     <= cfg.data;
                CFG_STALL_TABLE:    cfg_reg.stall_table    <= cfg.data;
                CFG_STARTUP_PHASES: cfg_reg.startup_phases <= cfg.data;
                CFG_STARTUP_TICKS:  cfg_reg.startup_ticks  <= cfg.data[SPAN_BITS-1:0];
                CFG_CLEAN_INTERVAL: cfg_reg.clean_interval <= cfg.data[SPAN_BITS-1:0];
                CFG_CLEAN_TICKS:    cfg_reg.clean_ticks    <= cfg.data[SPAN_BITS-1:0];
                CFG_MIN_DWELL:      cfg_reg.min_dwell      <= cfg.data[SPAN_BITS-1:0];
                CFG_TURN_OFF_TICKS: cfg_reg.turn_off_ticks <= cfg.data[SPAN_BITS-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode         <= MODE_IDLE;
            state_reg.start_phase  <= PH_IFILL;
            state_reg.prog_stall   <= '0;
            state_reg.phase_timer  <= '0;
            state_reg.mode_timer   <= '0;
            state_reg.long_latched <= 1'b0;
            state_reg.press_count  <= '0;
            state_reg.feeder       <= 1'b0;
            state_reg.heater       <= 1'b0;
            state_reg.fan          <= FAN_IDLE;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (in_acc)
                state_reg <= state_next;
            if (in_acc)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            res_reg <= res_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.mode            = res_reg.mode;
    assign out_ch.feed_phase      = res_reg.feed_phase;
    assign out_ch.fan_code        = res_reg.fan_code;
    assign out_ch.feeder_on       = res_reg.feeder_on;
    assign out_ch.heater_on       = res_reg.heater_on;
    assign out_ch.pending_presses = res_reg.pending_presses;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid_reg)
        else $error("accepted request produced no result");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == MODE_IDLE) |-> (!state_reg.feeder && !state_reg.heater))
        else $error("feeder or heater running in idle");

    a_off_fan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode == MODE_OFF) |-> (state_reg.fan == FAN_HIGH))
        else $error("fan not at full speed during turn-off");

    a_presses_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> $stable(state_reg.press_count))
        else $error("press count changed without a request");

    a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (res_reg.mode == state_reg.mode &&
                    res_reg.pending_presses == state_reg.press_count))
        else $error("result out of step with state");

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the pellet burner mode sequencer. Tick requests are driven
// through the input channel, a cycle model of the burner predicts every
// result, and a monitor compares each accepted result field by field with
// the oldest prediction. Covers reset settings, directed mode walks, extreme
// and invalid register writes, cleaning entry and shutdown, output back
// pressure and randomized tick streams under several register settings.
// ----------------------------------------------------------------------------
module tb_top
    import pbms_pkg::*;
();

    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_LIMIT     = 5000;

    logic clk = 1'b0;
    logic rst_n;

    pbms_in_if  in_ch ();
    pbms_out_if out_ch ();
    pbms_cfg_if cfg_ch ();

    pellet_burner_mode_sequencer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    int idle_pct      = 23;
    int hold_requests = 0;
    int holds_done    = 0;
    int fail_count    = 0;

    res_t expected_results[$];

    cfg_t                        burner_cfg;
    mode_t                       bm_mode;
    phase_t                      bm_start_ph;
    logic [NUM_PHASE_SLOTS-1:0]  bm_stall;
    logic [PHASE_TIMER_BITS-1:0] bm_ph_timer;
    logic [MODE_TIMER_BITS-1:0]  bm_mode_timer;
    logic                        bm_long;
    logic [PRESS_BITS-1:0]       bm_presses;
    logic                        bm_feeder;
    logic                        bm_heater;
    logic [2:0]                  bm_fan;

    function automatic void reset_burner_model();
        burner_cfg.fill_table     = '0;
        burner_cfg.stall_table    = '0;
        burner_cfg.startup_phases = '0;
        burner_cfg.startup_ticks  = 24'd6000;
        burner_cfg.clean_interval = 24'd36000;
        burner_cfg.clean_ticks    = 24'd200;
        burner_cfg.min_dwell      = 24'd50;
        burner_cfg.turn_off_ticks = 24'd3000;
        bm_mode       = MODE_IDLE;
        bm_start_ph   = PH_IFILL;
        bm_stall      = '0;
        bm_ph_timer   = '0;
        bm_mode_timer = '0;
        bm_long       = 1'b0;
        bm_presses    = '0;
        bm_feeder     = 1'b0;
        bm_heater     = 1'b0;
        bm_fan        = FAN_IDLE;
    endfunction

    function automatic logic [PHASE_TIMER_BITS-1:0] startup_len(int k);
        return PHASE_TIMER_BITS'(burner_cfg.startup_phases[START_LEN_BITS*k +: START_LEN_BITS]);
    endfunction

    function automatic void feed_step(logic [2:0] slot, logic [PHASE_TIMER_BITS-1:0] fill_len,
                                      logic [PHASE_TIMER_BITS-1:0] stall_len);
        if (!bm_stall[slot])
        begin
            bm_feeder = 1'b1;
            if (bm_ph_timer > fill_len)
            begin
                bm_feeder      = 1'b0;
                bm_ph_timer    = '0;
                bm_stall[slot] = 1'b1;
            end
        end
        else if (bm_ph_timer > stall_len)
        begin
            bm_ph_timer    = '0;
            bm_stall[slot] = 1'b0;
        end
    endfunction

    function automatic void startup_step();
        case (bm_start_ph)
            PH_IFILL:
            begin
                bm_feeder = 1'b1;
                bm_heater = 1'b1;
                bm_fan    = FAN_START;
                if (bm_ph_timer > startup_len(0))
                begin
                    bm_feeder   = 1'b0;
                    bm_ph_timer = '0;
                    bm_start_ph = PH_ISTALL;
                end
            end
            PH_ISTALL:
            begin
                if (bm_ph_timer > startup_len(1))
                begin
                    bm_ph_timer = '0;
                    bm_start_ph = PH_FILL;
                end
            end
            PH_FILL:
            begin
                bm_feeder = 1'b1;
                if (bm_ph_timer > startup_len(2))
                begin
                    bm_feeder   = 1'b0;
                    bm_ph_timer = '0;
                    bm_start_ph = PH_STALL;
                end
            end
            default:
            begin
                if (bm_ph_timer > startup_len(3))
                begin
                    bm_ph_timer = '0;
                    bm_start_ph = PH_FILL;
                end
            end
        endcase
    endfunction

    function automatic void burner_tick(logic lp, logic sp, output res_t r);
        mode_t      nxt;
        logic [2:0] slot;
        if (lp)
            bm_long = 1'b1;
        if (sp && bm_presses < PRESS_BITS'(MAX_PENDING_PRESSES))
            bm_presses++;
        if (bm_ph_timer != '1)
            bm_ph_timer++;
        if (bm_mode != MODE_IDLE && bm_mode_timer != '1)
            bm_mode_timer++;
        nxt = bm_mode;
        case (bm_mode)
            MODE_IDLE:
            begin
                if (bm_long)
                    nxt = MODE_START;
            end
            MODE_START:
            begin
                startup_step();
                if (bm_mode_timer >= burner_cfg.startup_ticks)
                    nxt = MODE_P1;
                if (bm_long)
                    nxt = MODE_OFF;
            end
            MODE_P1, MODE_P2, MODE_P3, MODE_P4, MODE_P5:
            begin
                slot = 3'(int'(bm_mode) - int'(MODE_P1));
                feed_step(slot,
                          PHASE_TIMER_BITS'(burner_cfg.fill_table[PROG_LEN_BITS*slot +: PROG_LEN_BITS]),
                          PHASE_TIMER_BITS'(burner_cfg.stall_table[PROG_LEN_BITS*slot +: PROG_LEN_BITS]));
                if (bm_mode_timer >= burner_cfg.clean_interval)
                    nxt = MODE_CLEAN;
                if (bm_presses != 0 && bm_mode_timer > burner_cfg.min_dwell)
                begin
                    nxt = (bm_mode == MODE_P5) ? MODE_P1 : mode_t'(bm_mode + 1);
                    bm_presses--;
                end
                if (bm_long)
                    nxt = MODE_OFF;
            end
            MODE_OFF:
            begin
                if (bm_mode_timer >= burner_cfg.turn_off_ticks)
                    nxt = MODE_IDLE;
            end
            default:
            begin
                feed_step(CLEAN_SLOT, CLEAN_FILL_TICKS, CLEAN_STALL_TICKS);
                if (bm_mode_timer >= burner_cfg.clean_ticks && bm_stall[CLEAN_SLOT])
                    nxt = MODE_P1;
                if (bm_long)
                    nxt = MODE_OFF;
            end
        endcase

        if (nxt != bm_mode)
        begin
            bm_mode_timer = '0;
            if (bm_mode == MODE_START)
            begin
                bm_heater = 1'b0;
                if (bm_presses != 0)
                    bm_presses--;
            end
            else if (bm_mode == MODE_OFF)
            begin
                bm_heater = 1'b0;
                bm_feeder = 1'b0;
            end
            if (nxt == MODE_IDLE)
                bm_fan = FAN_IDLE;
            else
            begin
                bm_long     = 1'b0;
                bm_ph_timer = '0;
                case (nxt)
                    MODE_START:
                        bm_start_ph = PH_IFILL;
                    MODE_P1, MODE_P2, MODE_P3, MODE_P4, MODE_P5:
                        bm_fan = 3'(int'(nxt) - int'(MODE_P1) + 1);
                    MODE_OFF:
                    begin
                        bm_presses = '0;
                        bm_fan     = FAN_HIGH;
                        bm_feeder  = 1'b0;
                    end
                    default:
                        bm_fan = FAN_HIGH;
                endcase
            end
            bm_mode = nxt;
        end

        r.mode = bm_mode;
        case (bm_mode)
            MODE_START:
                r.feed_phase = bm_start_ph;
            MODE_P1, MODE_P2, MODE_P3, MODE_P4, MODE_P5:
                r.feed_phase = bm_stall[3'(int'(bm_mode) - int'(MODE_P1))] ? PH_STALL : PH_FILL;
            MODE_CLEAN:
                r.feed_phase = bm_stall[CLEAN_SLOT] ? PH_STALL : PH_FILL;
            default:
                r.feed_phase = PH_FILL;
        endcase
        r.fan_code        = bm_fan;
        r.feeder_on       = bm_feeder;
        r.heater_on       = bm_heater;
        r.pending_presses = bm_presses;
    endfunction

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                $display("%0t unexpected result: mode %0d", $time, out_ch.mode);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("mode", 8'(want.mode), 8'(out_ch.mode));
                check_field("feed_phase", 8'(want.feed_phase), 8'(out_ch.feed_phase));
                check_field("fan_code", 8'(want.fan_code), 8'(out_ch.fan_code));
                check_field("feeder_on", 8'(want.feeder_on), 8'(out_ch.feeder_on));
                check_field("heater_on", 8'(want.heater_on), 8'(out_ch.heater_on));
                check_field("pending_presses", 8'(want.pending_presses),
                            8'(out_ch.pending_presses));
            end
        end
    end

    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
                out_ch.ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic send_tick(logic lp, logic sp);
        res_t r;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.long_press  <= lp;
        in_ch.short_press <= sp;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        burner_tick(lp, sp, r);
        expected_results.push_back(r);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        case (idx)
            CFG_FILL_TABLE:     burner_cfg.fill_table     = val;
            CFG_STALL_TABLE:    burner_cfg.stall_table    = val;
            CFG_STARTUP_PHASES: burner_cfg.startup_phases = val;
            CFG_STARTUP_TICKS:  burner_cfg.startup_ticks  = val[SPAN_BITS-1:0];
            CFG_CLEAN_INTERVAL: burner_cfg.clean_interval = val[SPAN_BITS-1:0];
            CFG_CLEAN_TICKS:    burner_cfg.clean_ticks    = val[SPAN_BITS-1:0];
            CFG_MIN_DWELL:      burner_cfg.min_dwell      = val[SPAN_BITS-1:0];
            CFG_TURN_OFF_TICKS: burner_cfg.turn_off_ticks = val[SPAN_BITS-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] rand_span(int hi, bit allow_max);
        logic [SPAN_BITS-1:0] v;
        if (allow_max && $urandom_range(99) < 4)
            v = '1;
        else
            v = SPAN_BITS'($urandom_range(hi));
        return {$urandom, 4'($urandom), v};
    endfunction

    task automatic pick_settings();
        logic [TABLE_BITS-1:0] fill_t;
        logic [TABLE_BITS-1:0] stall_t;
        logic [TABLE_BITS-1:0] su;
        su = '0;
        for (int k = 0; k < 5; k++)
        begin
            fill_t[PROG_LEN_BITS*k +: PROG_LEN_BITS] =
                ($urandom_range(99) < 5) ? '1 : PROG_LEN_BITS'($urandom_range(6));
            stall_t[PROG_LEN_BITS*k +: PROG_LEN_BITS] =
                ($urandom_range(99) < 5) ? '1 : PROG_LEN_BITS'($urandom_range(6));
        end
        for (int k = 0; k < 4; k++)
            su[START_LEN_BITS*k +: START_LEN_BITS] =
                ($urandom_range(99) < 5) ? '1 : START_LEN_BITS'($urandom_range(4));
        write_reg(CFG_FILL_TABLE, fill_t);
        write_reg(CFG_STALL_TABLE, stall_t);
        write_reg(CFG_STARTUP_PHASES, su);
        write_reg(CFG_STARTUP_TICKS, rand_span(30, 1'b1));
        write_reg(CFG_CLEAN_INTERVAL, rand_span(150, 1'b1));
        write_reg(CFG_CLEAN_TICKS, rand_span(20, 1'b1));
        write_reg(CFG_MIN_DWELL, rand_span(12, 1'b1));
        write_reg(CFG_TURN_OFF_TICKS, rand_span(10, 1'b0));
    endtask

    // walk the burner back to idle through turn-off
    task automatic drive_home();
        while (bm_mode != MODE_IDLE)
            send_tick(bm_mode != MODE_OFF, 1'b0);
    endtask

    task automatic test_reset_values();
        idle_pct = 0;
        send_tick(1'b1, 1'b0);
        repeat (40) send_tick(1'b0, 1'b0);
        // shorten start-up, keep the reset dwell
        wait_idle();
        write_reg(CFG_STARTUP_TICKS, 60'd45);
        while (bm_mode == MODE_START)
            send_tick(1'b0, 1'b0);
        repeat (60) send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        // shorten turn-off
        wait_idle();
        write_reg(CFG_TURN_OFF_TICKS, 60'd5);
        while (bm_mode != MODE_IDLE)
            send_tick(1'b0, 1'b0);
        idle_pct = 23;
    endtask

    task automatic test_directed();
        wait_idle();
        write_reg(CFG_FILL_TABLE, 60'h001_001_001_001_001);
        write_reg(CFG_STALL_TABLE, 60'h002_002_002_002_002);
        write_reg(CFG_STARTUP_PHASES, {15'd1, 15'd0, 15'd0, 15'd1});
        write_reg(CFG_STARTUP_TICKS, 60'd4);
        write_reg(CFG_CLEAN_INTERVAL, 60'd1000);
        write_reg(CFG_CLEAN_TICKS, 60'd0);
        write_reg(CFG_MIN_DWELL, 60'd0);
        write_reg(CFG_TURN_OFF_TICKS, 60'd2);
        drive_home();
        send_tick(1'b0, 1'b0);
        // saturate the press counter in idle
        repeat (16) send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);
        // start-up exit, then one program step per tick with wrap from program 5
        repeat (10) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        // long press during turn-off restarts right after idle
        send_tick(1'b1, 1'b0);
        repeat (4) send_tick(1'b0, 1'b0);
    endtask

    task automatic test_extremes();
        wait_idle();
        for (int i = CFG_FILL_TABLE; i <= CFG_TURN_OFF_TICKS; i++)
            write_reg(CFG_INDEX_BITS'(i), '0);
        // out-of-range indexes must not touch any register
        write_reg(8'hFF, '1);
        write_reg(CFG_INDEX_BITS'(CFG_TURN_OFF_TICKS + 1), '1);
        drive_home();
        repeat (40) send_tick($urandom_range(99) < 10, $urandom_range(99) < 40);
        wait_idle();
        for (int i = CFG_FILL_TABLE; i <= CFG_TURN_OFF_TICKS; i++)
            write_reg(CFG_INDEX_BITS'(i), '1);
        send_tick(1'b1, 1'b0);
        repeat (30) send_tick($urandom_range(99) < 5, $urandom_range(99) < 40);
    endtask

    task automatic test_cleaning();
        wait_idle();
        write_reg(CFG_FILL_TABLE, '0);
        write_reg(CFG_STALL_TABLE, '0);
        write_reg(CFG_STARTUP_TICKS, 60'd2);
        write_reg(CFG_CLEAN_INTERVAL, 60'd5);
        write_reg(CFG_CLEAN_TICKS, 60'd0);
        write_reg(CFG_MIN_DWELL, 60'hFFFFFF);
        write_reg(CFG_TURN_OFF_TICKS, 60'd3);
        drive_home();
        idle_pct = 0;
        send_tick(1'b1, 1'b0);
        while (bm_mode != MODE_CLEAN)
            send_tick(1'b0, 1'b0);
        repeat (20) send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        drive_home();
        idle_pct = 23;
    endtask

    task automatic test_backpressure();
        wait_idle();
        pick_settings();
        idle_pct = 0;
        hold_requests++;
        repeat (60) send_tick($urandom_range(99) < 5, $urandom_range(99) < 20);
        idle_pct = 23;
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 5; ph++)
        begin
            wait_idle();
            pick_settings();
            idle_pct = (ph == 3) ? 0 : 23;
            for (int n = 0; n < 100; n++)
            begin
                if ($urandom_range(99) < 10)
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
                else
                    send_tick($urandom_range(99) < 3, $urandom_range(99) < 12);
            end
        end
        idle_pct = 23;
    endtask

    task automatic finish_run();
        int n;
        n = 0;
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (4) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            fail_count += expected_results.size();
            $display("%0t %0d expected results never arrived", $time, expected_results.size());
        end
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.long_press  = 1'b0;
        in_ch.short_press = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        reset_burner_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed();
        test_extremes();
        test_cleaning();
        test_backpressure();
        test_random();
        finish_run();
    end

    initial
    begin
        #(5_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
